// ===== hw/rtl/sacl_pkg.sv =====
package sacl_pkg;

  localparam int AGE_W = 3;
  localparam logic [AGE_W-1:0] AGE_MAX = 3'd7;
  localparam int CNT_W = 32;

  localparam logic [1:0] OP_LOAD   = 2'd0;
  localparam logic [1:0] OP_STORE  = 2'd1;
  localparam logic [1:0] OP_MODIFY = 2'd2;

  localparam logic [1:0] OUT_HIT   = 2'd0;
  localparam logic [1:0] OUT_FILL  = 2'd1;
  localparam logic [1:0] OUT_EVICT = 2'd2;

  localparam logic [1:0] REG_SET_BITS   = 2'd0;
  localparam logic [1:0] REG_BLOCK_BITS = 2'd1;
  localparam logic [1:0] REG_WAYS       = 2'd2;

  localparam logic [2:0] RST_SET_BITS   = 3'd4;
  localparam logic [4:0] RST_BLOCK_BITS = 5'd4;
  localparam logic [3:0] RST_WAYS       = 4'd1;

  typedef struct packed {
    logic [1:0]  operation;
    logic [63:0] address;
  } in_item_t;

  typedef struct packed {
    logic [1:0]       outcome;
    logic             extra_hit;
    logic [CNT_W-1:0] hit_total;
    logic [CNT_W-1:0] miss_total;
    logic [CNT_W-1:0] eviction_total;
  } out_item_t;

  typedef struct packed {
    logic clear;
    logic start;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic clear_last;
  } status_t;

  typedef enum logic [2:0] {
    ST_CLEAR = 3'b001,
    ST_IDLE  = 3'b010,
    ST_LOOK  = 3'b100
  } state_t;

  function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v, input logic en);
    return (en && (v != {CNT_W{1'b1}})) ? v + CNT_W'(1) : v;
  endfunction

endpackage

// ===== hw/rtl/sacl_ctrl.sv =====
module sacl_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  input  sacl_pkg::status_t status,
  output sacl_pkg::cmd_t    cmd
);

  sacl_pkg::state_t state, state_next;
  logic out_valid_next;

  always_comb begin
    state_next = state;
    cmd = '0;
    in_ready = 1'b0;
    unique case (state)
      sacl_pkg::ST_CLEAR: begin
        cmd.clear = 1'b1;
        if (status.clear_last) state_next = sacl_pkg::ST_IDLE;
      end
      sacl_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.start = 1'b1;
          state_next = sacl_pkg::ST_LOOK;
        end
      end
      sacl_pkg::ST_LOOK: begin
        if (!out_valid || out_ready) begin
          cmd.finish = 1'b1;
          state_next = sacl_pkg::ST_IDLE;
        end
      end
      default: state_next = sacl_pkg::ST_CLEAR;
    endcase
  end

  always_comb begin
    out_valid_next = out_valid;
    if (out_ready) out_valid_next = 1'b0;
    if (cmd.finish) out_valid_next = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= sacl_pkg::ST_CLEAR;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      out_valid <= out_valid_next;
    end
  end

endmodule

// ===== hw/rtl/sacl_datapath.sv =====
module sacl_datapath #(
  parameter int MAX_SET_BITS = 6,
  parameter int MAX_WAYS     = 8,
  parameter int ADDR_WIDTH   = 64
) (
  input  logic                clk,
  input  logic                rst,
  input  sacl_pkg::cmd_t      cmd,
  output sacl_pkg::status_t   status,
  input  sacl_pkg::in_item_t  in_item,
  output sacl_pkg::out_item_t out_item,
  input  logic                cfg_write,
  input  logic [1:0]          cfg_index,
  input  logic [4:0]          cfg_data
);

  localparam int NUM_SETS = 1 << MAX_SET_BITS;
  localparam int IDX_W    = (MAX_SET_BITS > 0) ? MAX_SET_BITS : 1;
  localparam int WAY_W    = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
  localparam int WCNT_W   = $clog2(MAX_WAYS + 1);
  localparam int AW       = sacl_pkg::AGE_W;
  localparam int CW       = sacl_pkg::CNT_W;

  // config registers
  logic [2:0] set_bits;
  logic [4:0] block_bits;
  logic [3:0] ways_in_use;

  always_ff @(posedge clk) begin
    if (rst) begin
      set_bits    <= sacl_pkg::RST_SET_BITS;
      block_bits  <= sacl_pkg::RST_BLOCK_BITS;
      ways_in_use <= sacl_pkg::RST_WAYS;
    end else if (cfg_write) begin
      unique case (cfg_index)
        sacl_pkg::REG_SET_BITS:   set_bits    <= cfg_data[2:0];
        sacl_pkg::REG_BLOCK_BITS: block_bits  <= cfg_data;
        sacl_pkg::REG_WAYS:       ways_in_use <= cfg_data[3:0];
        default: ;
      endcase
    end
  end

  // address split
  logic [ADDR_WIDTH-1:0] addr_w;
  logic [3:0]            sb;
  logic [ADDR_WIDTH-1:0] set_sh;
  logic [IDX_W-1:0]      set_mask;
  logic [IDX_W-1:0]      set_in;
  logic [ADDR_WIDTH-1:0] tag_in;

  assign addr_w   = in_item.address[ADDR_WIDTH-1:0];
  assign sb       = (int'(set_bits) > MAX_SET_BITS) ? 4'(MAX_SET_BITS) : {1'b0, set_bits};
  assign set_sh   = addr_w >> block_bits;
  assign set_mask = ~({IDX_W{1'b1}} << sb);
  assign set_in   = set_sh[IDX_W-1:0] & set_mask;
  assign tag_in   = addr_w >> (6'(sb) + 6'(block_bits));

  // request registers
  logic [IDX_W-1:0]      set_q;
  logic [ADDR_WIDTH-1:0] tag_q;
  logic [1:0]            op_q;

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      set_q <= set_in;
      tag_q <= tag_in;
      op_q  <= in_item.operation;
    end
  end

  // clear sweep counter
  logic [IDX_W-1:0] clr_cnt;

  always_ff @(posedge clk) begin
    if (rst) clr_cnt <= '0;
    else if (cmd.clear) clr_cnt <= clr_cnt + IDX_W'(1);
  end

  assign status.clear_last = (clr_cnt == IDX_W'(NUM_SETS - 1));

  // set memories: meta is {valid, age} per way
  logic [MAX_WAYS-1:0][AW:0]           meta_mem [NUM_SETS];
  logic [MAX_WAYS-1:0][ADDR_WIDTH-1:0] tag_mem  [NUM_SETS];
  logic [MAX_WAYS-1:0][AW:0]           meta_rd, meta_wr;
  logic [MAX_WAYS-1:0][ADDR_WIDTH-1:0] tag_rd, tag_wr;
  logic                                meta_we;
  logic [IDX_W-1:0]                    meta_wa;
  logic [MAX_WAYS-1:0][AW:0]           meta_wd;
  logic                                hit_found;

  assign meta_we = cmd.clear | cmd.finish;
  assign meta_wa = cmd.clear ? clr_cnt : set_q;
  assign meta_wd = cmd.clear ? '0 : meta_wr;

  always_ff @(posedge clk) begin
    if (meta_we) meta_mem[meta_wa] <= meta_wd;
    if (cmd.start) meta_rd <= meta_mem[set_in];
  end

  always_ff @(posedge clk) begin
    if (cmd.finish && !hit_found) tag_mem[set_q] <= tag_wr;
    if (cmd.start) tag_rd <= tag_mem[set_in];
  end

  // lookup and replacement
  logic [WCNT_W-1:0] ways_eff;
  logic [WAY_W-1:0]  hit_way, empty_way, vic_way, touch;
  logic              empty_found, vic_found;
  logic [AW-1:0]     vic_age, hit_age;
  logic [AW:0]       limit;
  logic [1:0]        outcome;

  assign ways_eff = (ways_in_use == 4'd0) ? WCNT_W'(1) :
                    (int'(ways_in_use) > MAX_WAYS) ? WCNT_W'(MAX_WAYS) :
                    WCNT_W'(ways_in_use);

  always_comb begin
    hit_found   = 1'b0;
    empty_found = 1'b0;
    vic_found   = 1'b0;
    hit_way     = '0;
    empty_way   = '0;
    vic_way     = '0;
    vic_age     = '0;
    for (int w = 0; w < MAX_WAYS; w++) begin
      if (w < int'(ways_eff)) begin
        if (meta_rd[w][AW]) begin
          if (!hit_found && tag_rd[w] == tag_q) begin
            hit_found = 1'b1;
            hit_way   = WAY_W'(w);
          end
          if (!vic_found || meta_rd[w][AW-1:0] >= vic_age) begin
            vic_found = 1'b1;
            vic_way   = WAY_W'(w);
            vic_age   = meta_rd[w][AW-1:0];
          end
        end else begin
          empty_found = 1'b1;
          empty_way   = WAY_W'(w);
        end
      end
    end
  end

  assign hit_age = meta_rd[hit_way][AW-1:0];

  always_comb begin
    if (hit_found) begin
      touch   = hit_way;
      limit   = {1'b0, hit_age};
      outcome = sacl_pkg::OUT_HIT;
    end else if (empty_found) begin
      touch   = empty_way;
      limit   = {1'b1, {AW{1'b0}}};
      outcome = sacl_pkg::OUT_FILL;
    end else begin
      touch   = vic_way;
      limit   = {1'b0, vic_age};
      outcome = sacl_pkg::OUT_EVICT;
    end
  end

  always_comb begin
    meta_wr = meta_rd;
    for (int w = 0; w < MAX_WAYS; w++) begin
      if (w < int'(ways_eff) && meta_rd[w][AW] && ({1'b0, meta_rd[w][AW-1:0]} < limit) &&
          meta_rd[w][AW-1:0] != sacl_pkg::AGE_MAX) begin
        meta_wr[w][AW-1:0] = meta_rd[w][AW-1:0] + AW'(1);
      end
    end
    meta_wr[touch] = {1'b1, {AW{1'b0}}};
  end

  always_comb begin
    tag_wr = tag_rd;
    tag_wr[touch] = tag_q;
  end

  // counters and result register
  logic [CW-1:0] hit_count, miss_count, eviction_count;
  logic [CW-1:0] hit_one, hit_next, miss_next, evict_next;
  logic          extra;

  assign extra      = (op_q == sacl_pkg::OP_MODIFY);
  assign hit_one    = sacl_pkg::sat_inc(hit_count, hit_found);
  assign hit_next   = sacl_pkg::sat_inc(hit_one, extra);
  assign miss_next  = sacl_pkg::sat_inc(miss_count, !hit_found);
  assign evict_next = sacl_pkg::sat_inc(eviction_count, outcome == sacl_pkg::OUT_EVICT);

  always_ff @(posedge clk) begin
    if (rst) begin
      hit_count      <= '0;
      miss_count     <= '0;
      eviction_count <= '0;
    end else if (cmd.finish) begin
      hit_count      <= hit_next;
      miss_count     <= miss_next;
      eviction_count <= evict_next;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      out_item.outcome        <= outcome;
      out_item.extra_hit      <= extra;
      out_item.hit_total      <= hit_next;
      out_item.miss_total     <= miss_next;
      out_item.eviction_total <= evict_next;
    end
  end

endmodule

// ===== hw/rtl/set_assoc_cache_lru_model.sv =====
// an item is accepted in the idle state; its result is registered on leaving the look state, once the output is free
// a new item is taken only after the previous one has been written back to the set memories
// a result waiting in the output register holds off only the write-back of the next item
// reset: synchronous, active high; config returns to set_bits 4, block_bits 4, ways 1
// after reset a sweep clears the valid bits and ages of every set, with in_ready low
module set_assoc_cache_lru_model #(
  parameter int MAX_SET_BITS = 6,
  parameter int MAX_WAYS     = 8,
  parameter int ADDR_WIDTH   = 64
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  sacl_pkg::in_item_t  in_item,
  output logic                out_valid,
  input  logic                out_ready,
  output sacl_pkg::out_item_t out_item,
  input  logic                cfg_write,
  input  logic [1:0]          cfg_index,
  input  logic [4:0]          cfg_data
);

  sacl_pkg::cmd_t    cmd;
  sacl_pkg::status_t status;

  sacl_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .cmd       (cmd)
  );

  sacl_datapath #(
    .MAX_SET_BITS (MAX_SET_BITS),
    .MAX_WAYS     (MAX_WAYS),
    .ADDR_WIDTH   (ADDR_WIDTH)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .status    (status),
    .in_item   (in_item),
    .out_item  (out_item),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

endmodule

// ===== tb/sv/tb.sv =====
`timescale 1ns / 1ps

module tb;

  localparam int MAX_SET_BITS = 6;
  localparam int MAX_WAYS     = 8;
  localparam int NUM_LINES    = (1 << MAX_SET_BITS) * MAX_WAYS;
  localparam int NUM_PHASES   = 8;
  localparam int PHASE_ITEMS  = 180;
  localparam int DRAIN_LIMIT  = 20000;
  localparam logic [1:0] OP_UNKNOWN = 2'd3;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                in_valid = 1'b0;
  logic                in_ready;
  sacl_pkg::in_item_t  in_item = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  sacl_pkg::out_item_t out_item;
  logic       cfg_write = 1'b0;
  logic [1:0] cfg_index = sacl_pkg::REG_SET_BITS;
  logic [4:0] cfg_data = '0;

  sacl_pkg::in_item_t  access_q[$];
  sacl_pkg::out_item_t expected_q[$];
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int fail_count = 0;
  int hits_seen = 0;
  int fills_seen = 0;
  int evicts_seen = 0;
  int modifies_seen = 0;
  int settings_used = 0;

  // cache shadow state
  logic [2:0]  pred_set_bits;
  logic [4:0]  pred_block_bits;
  logic [3:0]  pred_ways;
  logic        line_valid_q [NUM_LINES];
  logic [63:0] line_tag_q   [NUM_LINES];
  logic [2:0]  line_age_q   [NUM_LINES];
  logic [31:0] hit_cnt;
  logic [31:0] miss_cnt;
  logic [31:0] evict_cnt;

  set_assoc_cache_lru_model u_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic logic [31:0] bump(input logic [31:0] v);
    return (v == 32'hFFFF_FFFF) ? v : v + 32'd1;
  endfunction

  // ways more recent than limit get one step older
  function automatic void age_ways(input int base, input int ways, input int limit);
    for (int w = 0; w < ways; w++) begin
      if (line_valid_q[base + w] && int'(line_age_q[base + w]) < limit &&
          line_age_q[base + w] != sacl_pkg::AGE_MAX) begin
        line_age_q[base + w] = line_age_q[base + w] + 3'd1;
      end
    end
  endfunction

  function automatic sacl_pkg::out_item_t cache_lookup(input sacl_pkg::in_item_t acc);
    sacl_pkg::out_item_t res;
    int          sb, ways, set_idx, base, hit_way, empty_way, victim, slot;
    logic [63:0] tag;
    sb = (pred_set_bits > MAX_SET_BITS) ? MAX_SET_BITS : int'(pred_set_bits);
    ways = (pred_ways == 0) ? 1 : ((pred_ways > MAX_WAYS) ? MAX_WAYS : int'(pred_ways));
    set_idx = int'((acc.address >> pred_block_bits) & ((64'd1 << sb) - 64'd1));
    tag = acc.address >> (sb + int'(pred_block_bits));
    base = set_idx * MAX_WAYS;
    hit_way = -1;
    empty_way = -1;
    victim = -1;
    for (int w = 0; w < ways; w++) begin
      if (line_valid_q[base + w]) begin
        if (hit_way < 0 && line_tag_q[base + w] == tag) hit_way = w;
        if (victim < 0 || line_age_q[base + w] >= line_age_q[base + victim]) victim = w;
      end else begin
        empty_way = w;
      end
    end
    res = '0;
    if (hit_way >= 0) begin
      slot = base + hit_way;
      age_ways(base, ways, int'(line_age_q[slot]));
      line_age_q[slot] = '0;
      hit_cnt = bump(hit_cnt);
      res.outcome = sacl_pkg::OUT_HIT;
    end else if (empty_way >= 0) begin
      slot = base + empty_way;
      age_ways(base, ways, int'(sacl_pkg::AGE_MAX) + 1);
      line_valid_q[slot] = 1'b1;
      line_tag_q[slot] = tag;
      line_age_q[slot] = '0;
      miss_cnt = bump(miss_cnt);
      res.outcome = sacl_pkg::OUT_FILL;
    end else begin
      slot = base + victim;
      age_ways(base, ways, int'(line_age_q[slot]));
      line_tag_q[slot] = tag;
      line_age_q[slot] = '0;
      miss_cnt = bump(miss_cnt);
      evict_cnt = bump(evict_cnt);
      res.outcome = sacl_pkg::OUT_EVICT;
    end
    if (acc.operation == sacl_pkg::OP_MODIFY) begin
      hit_cnt = bump(hit_cnt);
      res.extra_hit = 1'b1;
    end
    res.hit_total = hit_cnt;
    res.miss_total = miss_cnt;
    res.eviction_total = evict_cnt;
    return res;
  endfunction

  function automatic void check_field(input string name, input logic [31:0] want,
                                      input logic [31:0] got);
    if (got !== want) begin
      $error("%s mismatch: expected %0d, got %0d", name, want, got);
      fail_count++;
    end
  endfunction

  // driver
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_ready) begin
      if (access_q.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        in_valid <= 1'b1;
        in_item <= access_q.pop_front();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    out_ready <= !rst && ($urandom_range(0, 99) >= recv_stall_pct);
  end

  // monitor
  always @(posedge clk) begin
    sacl_pkg::out_item_t want;
    if (!rst) begin
      if (out_valid && out_ready) begin
        if (expected_q.size() == 0) begin
          $error("result with no access outstanding: %p", out_item);
          fail_count++;
        end else begin
          want = expected_q.pop_front();
          check_field("outcome", 32'(want.outcome), 32'(out_item.outcome));
          check_field("extra_hit", 32'(want.extra_hit), 32'(out_item.extra_hit));
          check_field("hit_total", want.hit_total, out_item.hit_total);
          check_field("miss_total", want.miss_total, out_item.miss_total);
          check_field("eviction_total", want.eviction_total, out_item.eviction_total);
          case (want.outcome)
            sacl_pkg::OUT_HIT:  hits_seen++;
            sacl_pkg::OUT_FILL: fills_seen++;
            default:            evicts_seen++;
          endcase
          if (want.extra_hit) modifies_seen++;
        end
      end
      if (in_valid && in_ready) expected_q.push_back(cache_lookup(in_item));
    end
  end

  task automatic write_reg(input logic [1:0] idx, input logic [4:0] value);
    @(posedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    case (idx)
      sacl_pkg::REG_SET_BITS:   pred_set_bits = value[2:0];
      sacl_pkg::REG_BLOCK_BITS: pred_block_bits = value;
      sacl_pkg::REG_WAYS:       pred_ways = value[3:0];
      default: ;
    endcase
  endtask

  task automatic apply_config(input logic [2:0] sb, input logic [4:0] bb,
                              input logic [3:0] ways);
    write_reg(sacl_pkg::REG_SET_BITS, 5'(sb));
    write_reg(sacl_pkg::REG_BLOCK_BITS, bb);
    write_reg(sacl_pkg::REG_WAYS, 5'(ways));
    @(posedge clk);
    cfg_write <= 1'b0;
    settings_used++;
  endtask

  task automatic push_access(input logic [1:0] op, input logic [63:0] addr);
    sacl_pkg::in_item_t acc;
    acc.operation = op;
    acc.address = addr;
    access_q.push_back(acc);
  endtask

  task automatic wait_drain();
    int n;
    n = 0;
    while ((access_q.size() != 0 || in_valid || expected_q.size() != 0) &&
           n < DRAIN_LIMIT) begin
      @(posedge clk);
      n++;
    end
    repeat (4) @(posedge clk);
  endtask

  // half the lines are crowded into sets 0 and 1 to force evictions
  function automatic logic [63:0] random_line(input logic [63:0] set_mask);
    logic [63:0] a;
    a = {$urandom, $urandom};
    if ($urandom_range(0, 1) == 0)
      a = (a & ~set_mask) | ((64'($urandom_range(0, 1)) << pred_block_bits) & set_mask);
    return a;
  endfunction

  task automatic queue_random(input int count);
    logic [63:0] pool[$];
    logic [63:0] addr, set_mask, off_mask;
    int          sb, roll;
    sb = (pred_set_bits > MAX_SET_BITS) ? MAX_SET_BITS : int'(pred_set_bits);
    off_mask = (64'd1 << pred_block_bits) - 64'd1;
    set_mask = ((64'd1 << sb) - 64'd1) << pred_block_bits;
    repeat ($urandom_range(2, 24)) pool.push_back(random_line(set_mask));
    repeat (count) begin
      roll = $urandom_range(0, 99);
      if (roll < 4) pool[$urandom_range(0, pool.size() - 1)] = random_line(set_mask);
      if (roll >= 92) begin
        addr = {$urandom, $urandom};
      end else begin
        addr = (pool[$urandom_range(0, pool.size() - 1)] & ~off_mask) |
               ({$urandom, $urandom} & off_mask);
      end
      push_access(2'($urandom_range(0, 3)), addr);
    end
  endtask

  initial begin
    logic [2:0] phase_sb   [NUM_PHASES];
    logic [4:0] phase_bb   [NUM_PHASES];
    logic [3:0] phase_ways [NUM_PHASES];
    phase_sb   = '{3'd0, 3'd7, 3'd6, 3'd3, 3'd2, 3'd1, 3'd5, 3'd6};
    phase_bb   = '{5'd0, 5'd31, 5'd16, 5'd5, 5'd4, 5'd2, 5'd0, 5'd6};
    phase_ways = '{4'd1, 4'd15, 4'd8, 4'd4, 4'd0, 4'd3, 4'd8, 4'd2};
    for (int i = 0; i < NUM_LINES; i++) begin
      line_valid_q[i] = 1'b0;
      line_tag_q[i] = '0;
      line_age_q[i] = '0;
    end
    pred_set_bits = sacl_pkg::RST_SET_BITS;
    pred_block_bits = sacl_pkg::RST_BLOCK_BITS;
    pred_ways = sacl_pkg::RST_WAYS;
    hit_cnt = '0;
    miss_cnt = '0;
    evict_cnt = '0;

    repeat (4) @(posedge clk);
    rst <= 1'b0;
    do @(posedge clk); while (in_ready !== 1'b1);

    // reset config first, then 4 sets of 2 ways with 8-byte blocks
    push_access(sacl_pkg::OP_LOAD, 64'h0);
    push_access(sacl_pkg::OP_MODIFY, 64'h8);
    wait_drain();
    apply_config(3'd2, 5'd3, 4'd2);
    push_access(sacl_pkg::OP_LOAD, 64'h0);
    push_access(sacl_pkg::OP_LOAD, 64'h0);
    push_access(sacl_pkg::OP_STORE, 64'hFFFF_FFFF_FFFF_FFFF);
    push_access(sacl_pkg::OP_MODIFY, 64'hFFFF_FFFF_FFFF_FFF8);
    push_access(OP_UNKNOWN, 64'h0);
    push_access(sacl_pkg::OP_LOAD, 64'h20);
    push_access(sacl_pkg::OP_MODIFY, 64'h40);
    push_access(sacl_pkg::OP_STORE, 64'h8000_0000_0000_0000);
    push_access(sacl_pkg::OP_LOAD, 64'h20);
    push_access(sacl_pkg::OP_LOAD, 64'h5555_5555_5555_5555);
    push_access(sacl_pkg::OP_STORE, 64'hAAAA_AAAA_AAAA_AAAA);
    push_access(sacl_pkg::OP_MODIFY, 64'h5555_5555_5555_5550);
    push_access(OP_UNKNOWN, 64'hAAAA_AAAA_AAAA_AAAA);
    push_access(sacl_pkg::OP_LOAD, 64'h7FFF_FFFF_FFFF_FFFF);
    push_access(sacl_pkg::OP_MODIFY, 64'h8000_0000_0000_0000);
    push_access(sacl_pkg::OP_STORE, 64'h0000_0000_0000_0001);
    wait_drain();

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      apply_config(phase_sb[ph], phase_bb[ph], phase_ways[ph]);
      case (ph % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 86; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 86; end
        default: begin send_idle_pct = 17; recv_stall_pct = 17; end
      endcase
      if (ph == 2) begin
        // hold the sender until every result is back, then resume
        queue_random(PHASE_ITEMS / 2);
        wait_drain();
        queue_random(PHASE_ITEMS - PHASE_ITEMS / 2);
      end else begin
        queue_random(PHASE_ITEMS);
      end
      wait_drain();
    end

    if (expected_q.size() != 0 || access_q.size() != 0) begin
      $error("%0d results never arrived, %0d items never sent",
             expected_q.size(), access_q.size());
      fail_count++;
    end
    $display("run covered %0d configurations: %0d hits, %0d fills, %0d evictions",
             settings_used, hits_seen, fills_seen, evicts_seen);
    $display("%0d modify extra hits, final hit/miss/evict totals %0d/%0d/%0d",
             modifies_seen, hit_cnt, miss_cnt, evict_cnt);
    if (fail_count == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  initial begin
    #3_000_000;
    $display("FAILED: results differ");
    $finish;
  end

endmodule

// ===== set_assoc_cache_lru_model.f =====
hw/rtl/sacl_pkg.sv
hw/rtl/sacl_ctrl.sv
hw/rtl/sacl_datapath.sv
hw/rtl/set_assoc_cache_lru_model.sv
tb/sv/tb.sv
